// ===== rtl/core/mono_frame_diff_to_rgb888_core_defines.svh =====
// Assertion macros shared by the mono frame diff core.
// No dependencies; included by the modules that carry checks.
`ifndef MONO_FRAME_DIFF_TO_RGB888_CORE_DEFINES_SVH
`define MONO_FRAME_DIFF_TO_RGB888_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfd check failed");

// Consequent must hold in the cycle after the antecedent.
`define MFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfd check failed");

`endif

// ===== rtl/core/mfd_pkg.sv =====
// Shared types, constants and helpers of the mono frame diff core.
// No dependencies.
package mfd_pkg;

   localparam int PANEL_WIDTH_DEF  = 64;
   localparam int PANEL_HEIGHT_DEF = 32;

   localparam int COLUMN_W = 6;
   localparam int PAGE_W   = 2;
   localparam int BITS_W   = 8;
   localparam int X_W      = 6;
   localparam int Y_W      = 5;
   localparam int CHAN_W   = 8;
   localparam int COLOR_W  = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ON_COLOR  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_COLOR = 1'b1;

   localparam logic [COLOR_W-1:0] ON_COLOR_RST  = 16'hFFFF;
   localparam logic [COLOR_W-1:0] OFF_COLOR_RST = 16'h0000;

   // One byte handed to the pixel emitter: position, pixel bits, rows to draw.
   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [PAGE_W-1:0]   page;
      logic [BITS_W-1:0]   bits;
      logic [BITS_W-1:0]   mask;
   } emit_load_type;

   // Index of the lowest set bit; zero for an empty mask.
   function automatic logic [2:0] low_bit_idx(input logic [BITS_W-1:0] m);
      logic [2:0] r;
      r = '0;
      for (int i = BITS_W - 1; i >= 0; i--) begin
         if (m[i]) r = 3'(i);
      end
      return r;
   endfunction

   function automatic logic [CHAN_W-1:0] red_of(input logic [COLOR_W-1:0] c);
      return {c[15:11], 3'b000};
   endfunction

   function automatic logic [CHAN_W-1:0] green_of(input logic [COLOR_W-1:0] c);
      return {c[10:5], 2'b00};
   endfunction

   function automatic logic [CHAN_W-1:0] blue_of(input logic [COLOR_W-1:0] c);
      return {c[4:0], 3'b000};
   endfunction

endpackage

// ===== rtl/core/mfd_if.sv =====
// Valid/ready channel interfaces of the mono frame diff core.
// Depends on mfd_pkg for field widths.
interface mfd_req_if;
   import mfd_pkg::*;

   logic                valid;
   logic                ready;
   logic [COLUMN_W-1:0] column;
   logic [PAGE_W-1:0]   page;
   logic [BITS_W-1:0]   pixel_bits;
   logic                frame_end;

   modport source (output valid, output column, output page, output pixel_bits,
                   output frame_end, input ready);
   modport sink   (input valid, input column, input page, input pixel_bits,
                   input frame_end, output ready);
endinterface

interface mfd_rsp_if;
   import mfd_pkg::*;

   logic              valid;
   logic              ready;
   logic [X_W-1:0]    pixel_x;
   logic [Y_W-1:0]    pixel_y;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic              run_last;

   modport source (output valid, output pixel_x, output pixel_y, output red,
                   output green, output blue, output run_last, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input red,
                   input green, input blue, input run_last, output ready);
endinterface

// ===== rtl/core/mfd_frame_mem.sv =====
// Shown-frame copy: one write port, one read port with registered data.
// No package dependencies.
module mfd_frame_mem #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data
);
   logic [7:0] frame_mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) frame_mem[wr_addr] <= wr_data;
   end

   // Read-before-write on a same-address collision; the caller forwards.
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= frame_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/mfd_pixel_emit.sv =====
// Pixel emitter: walks one byte's change mask, one pixel transfer a cycle unless
// the output stalls, into an output register. Depends on mfd_pkg and mfd_rsp_if.
`include "mono_frame_diff_to_rgb888_core_defines.svh"

module mfd_pixel_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_valid,
   input  mfd_pkg::emit_load_type load,
   output logic                   load_free,
   input  logic [15:0]            on_color,
   input  logic [15:0]            off_color,
   mfd_rsp_if.source              rsp_ch
);
   import mfd_pkg::*;

   emit_load_type     ld_ff;
   logic [BITS_W-1:0] mask_ff, mask_in;
   logic [2:0]        k;
   logic [BITS_W-1:0] rest;
   logic              pix_fire;
   logic [COLOR_W-1:0] color;

   logic              rsp_valid_ff;
   logic [X_W-1:0]    rsp_x_ff;
   logic [Y_W-1:0]    rsp_y_ff;
   logic [CHAN_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic              rsp_last_ff;

   assign k        = low_bit_idx(mask_ff);
   assign rest     = mask_ff & (mask_ff - 8'd1);
   assign pix_fire = (mask_ff != '0) && (!rsp_valid_ff || rsp_ch.ready);
   assign load_free = (mask_ff == '0) || (pix_fire && (rest == '0));
   assign color    = ld_ff.bits[k] ? on_color : off_color;

   always_comb begin
      mask_in = mask_ff;
      if (load_valid) mask_in = load.mask;
      else if (pix_fire) mask_in = rest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         if (pix_fire) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid) ld_ff <= load;
      if (pix_fire) begin
         rsp_x_ff     <= ld_ff.column;
         rsp_y_ff     <= {ld_ff.page, k};
         rsp_red_ff   <= red_of(color);
         rsp_green_ff <= green_of(color);
         rsp_blue_ff  <= blue_of(color);
         rsp_last_ff  <= (rest == '0);
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.pixel_x  = rsp_x_ff;
   assign rsp_ch.pixel_y  = rsp_y_ff;
   assign rsp_ch.red      = rsp_red_ff;
   assign rsp_ch.green    = rsp_green_ff;
   assign rsp_ch.blue     = rsp_blue_ff;
   assign rsp_ch.run_last = rsp_last_ff;

   `MFD_ASSERT_SAME(a_load_when_free, clock, reset, load_valid, load_free)
   `MFD_ASSERT_NEXT(a_fire_fills_out, clock, reset, pix_fire, rsp_valid_ff)
   `MFD_ASSERT_NEXT(a_mask_shrinks, clock, reset, !load_valid && pix_fire, mask_ff == $past(rest))
endmodule

// ===== rtl/core/mono_frame_diff_to_rgb888_core.sv =====
// Top level of the mono frame diff core: accept stage, shown-frame compare,
// colour registers. Depends on mfd_pkg, mfd_if, mfd_frame_mem, mfd_pixel_emit.
//
// Takes one framebuffer byte per transfer and gives one pixel write per changed
// bit, lowest bit first, at one pixel transfer per cycle while the output is
// ready. A byte stays in the pixel emitter until it has drawn its pixels (up to
// 8; a full repaint draws 8), and the next byte is taken while the current one
// drains, so the rate is set by the emitter's one-pixel-per-cycle walk. The
// shown-frame memory read is registered; a back-to-back byte at the same
// position is forwarded from the write. There is no clearing pass after reset:
// the first frame repaints everything.
`include "mono_frame_diff_to_rgb888_core_defines.svh"

module mono_frame_diff_to_rgb888_core #(
   parameter int PANEL_WIDTH  = mfd_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = mfd_pkg::PANEL_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   mfd_req_if.sink                        req_ch,
   mfd_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [mfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mfd_pkg::COLOR_W-1:0]    csr_wdata
);
   import mfd_pkg::*;

   localparam int STORE_DEPTH = PANEL_WIDTH * PANEL_HEIGHT / 8;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [PAGE_W-1:0]   page;
      logic [BITS_W-1:0]   bits;
      logic                frame_end;
      logic                inb;
   } s1_type;

   logic [COLOR_W-1:0] on_color_ff, off_color_ff;
   logic [COLOR_W-1:0] shown_on_ff, shown_off_ff;
   logic               first_frame_ff;

   logic               s1_valid_ff;
   s1_type             s1_ff;
   logic [ADDR_W-1:0]  s1_idx_ff;
   logic               fwd_ff;
   logic [BITS_W-1:0]  fwd_data_ff;

   logic               req_fire;
   logic               req_inb;
   logic [ADDR_W-1:0]  req_idx;
   logic [BITS_W-1:0]  mem_rd_data;
   logic [BITS_W-1:0]  prior;
   logic               full_paint;
   logic [BITS_W-1:0]  change;
   logic               s1_advance;
   logic               s1_stall;
   logic               fend_take;
   logic               mem_wr;
   logic               emit_free;
   logic               emit_load_valid;
   emit_load_type      emit_load;

   assign req_inb = (32'(req_ch.column) < PANEL_WIDTH) &&
                    (32'(req_ch.page) * 8 < PANEL_HEIGHT);
   assign req_idx = ADDR_W'(32'(req_ch.page) * PANEL_WIDTH + 32'(req_ch.column));

   assign prior      = fwd_ff ? fwd_data_ff : mem_rd_data;
   assign full_paint = first_frame_ff || (on_color_ff != shown_on_ff) ||
                       (off_color_ff != shown_off_ff);
   assign change     = !s1_ff.inb ? '0 : (full_paint ? 8'hFF : (s1_ff.bits ^ prior));

   // Bytes that draw nothing pass without waiting for the emitter.
   assign s1_advance      = s1_valid_ff && ((change == '0) || emit_free);
   assign s1_stall        = s1_valid_ff && !s1_advance;
   assign fend_take       = s1_advance && s1_ff.frame_end;
   assign mem_wr          = s1_advance && s1_ff.inb;
   assign emit_load_valid = s1_advance && (change != '0);
   assign emit_load       = '{column: s1_ff.column, page: s1_ff.page,
                              bits: s1_ff.bits, mask: change};

   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_color_ff  <= ON_COLOR_RST;
         off_color_ff <= OFF_COLOR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ON_COLOR:  on_color_ff  <= csr_wdata;
            CSR_OFF_COLOR: off_color_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_frame_ff <= 1'b1;
         shown_on_ff    <= '0;
         shown_off_ff   <= '0;
         s1_valid_ff    <= 1'b0;
         fwd_ff         <= 1'b0;
      end else begin
         if (fend_take) begin
            first_frame_ff <= 1'b0;
            shown_on_ff    <= on_color_ff;
            shown_off_ff   <= off_color_ff;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
            // Forward a write landing on the entry being read this cycle.
            fwd_ff      <= mem_wr && (s1_idx_ff == req_idx);
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
            fwd_ff      <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff       <= '{column: req_ch.column, page: req_ch.page,
                          bits: req_ch.pixel_bits, frame_end: req_ch.frame_end,
                          inb: req_inb};
         s1_idx_ff   <= req_idx;
         fwd_data_ff <= s1_ff.bits;
      end
   end

   mfd_frame_mem #(
      .DEPTH(STORE_DEPTH)
   ) u_frame_mem (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (req_idx),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr),
      .wr_addr (s1_idx_ff),
      .wr_data (s1_ff.bits)
   );

   mfd_pixel_emit u_pixel_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (emit_load_valid),
      .load       (emit_load),
      .load_free  (emit_free),
      .on_color   (on_color_ff),
      .off_color  (off_color_ff),
      .rsp_ch     (rsp_ch)
   );

   `MFD_ASSERT_NEXT(a_fend_clears_first, clock, reset, fend_take, !first_frame_ff)
   `MFD_ASSERT_SAME(a_fwd_has_item, clock, reset, fwd_ff, s1_valid_ff)
   `MFD_ASSERT_NEXT(a_s1_holds, clock, reset, s1_stall, s1_valid_ff && $stable(s1_idx_ff))
endmodule

// ===== tb/mono_frame_diff_to_rgb888_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of mono_frame_diff_to_rgb888_core: frame bytes in,
// pixel writes out, checked against an in-bench frame-diff predictor.
// Depends on mfd_pkg, mfd_if and the core RTL.
module mono_frame_diff_to_rgb888_core_tb;
   import mfd_pkg::*;

   localparam int PANEL_W       = PANEL_WIDTH_DEF;
   localparam int PANEL_H       = PANEL_HEIGHT_DEF;
   localparam int COPY_DEPTH    = PANEL_W * PANEL_H / 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_BYTES  = 300;

   typedef struct packed {
      logic [X_W-1:0]    x;
      logic [Y_W-1:0]    y;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              run_last;
   } pixel_write_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COLOR_W-1:0]   csr_wdata;

   mfd_req_if req_ch ();
   mfd_rsp_if rsp_ch ();

   mono_frame_diff_to_rgb888_core #(
      .PANEL_WIDTH (PANEL_W),
      .PANEL_HEIGHT(PANEL_H)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Predictor state: what the panel shows and the colours it was drawn with.
   logic [BITS_W-1:0]  panel_copy [COPY_DEPTH];
   bit                 panel_written [COPY_DEPTH];
   int                 written_positions [$];
   bit                 first_frame_pending;
   logic [COLOR_W-1:0] latched_on_color;
   logic [COLOR_W-1:0] latched_off_color;
   logic [COLOR_W-1:0] on_color_reg;
   logic [COLOR_W-1:0] off_color_reg;

   pixel_write_type pending_pixels [$];
   int error_count;
   int hold_off_left;
   int burst_left;
   int last_position;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("mono_frame_diff_to_rgb888_core_tb: errors");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic bit repaint_forced();
      return first_frame_pending || on_color_reg != latched_on_color ||
             off_color_reg != latched_off_color;
   endfunction

   // Work out the pixel writes one accepted byte causes and update the copy.
   task automatic predict_pixels(input logic [COLUMN_W-1:0] col, input logic [PAGE_W-1:0] pg,
                                 input logic [BITS_W-1:0] bits, input logic fend);
      int idx;
      int total;
      int emitted;
      logic [BITS_W-1:0] changed;
      logic [COLOR_W-1:0] c;
      pixel_write_type pw;
      if (int'(col) < PANEL_W && int'(pg) * 8 < PANEL_H) begin
         idx = int'(pg) * PANEL_W + int'(col);
         changed = repaint_forced() ? 8'hFF : (bits ^ panel_copy[idx]);
         total = $countones(changed);
         emitted = 0;
         for (int k = 0; k < 8; k++) begin
            if (changed[k]) begin
               c = bits[k] ? on_color_reg : off_color_reg;
               pw.x        = X_W'(col);
               pw.y        = Y_W'(int'(pg) * 8 + k);
               pw.red      = CHAN_W'(c[15:11]) << 3;
               pw.green    = CHAN_W'(c[10:5]) << 2;
               pw.blue     = CHAN_W'(c[4:0]) << 3;
               pw.run_last = (emitted == total - 1);
               pending_pixels.push_back(pw);
               emitted++;
            end
         end
         panel_copy[idx] = bits;
         if (!panel_written[idx]) begin
            panel_written[idx] = 1'b1;
            written_positions.push_back(idx);
         end
      end
      if (fend) begin
         latched_on_color  = on_color_reg;
         latched_off_color = off_color_reg;
         first_frame_pending = 1'b0;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer
   // with valid still high.
   task automatic send_byte(input logic [COLUMN_W-1:0] col, input logic [PAGE_W-1:0] pg,
                            input logic [BITS_W-1:0] bits, input logic fend);
      req_ch.valid      <= 1'b1;
      req_ch.column     <= col;
      req_ch.page       <= pg;
      req_ch.pixel_bits <= bits;
      req_ch.frame_end  <= fend;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_pixels(col, pg, bits, fend);
      last_position = int'(pg) * PANEL_W + int'(col);
      @(negedge clock);
   endtask

   // Bursts of back-to-back bytes separated by random gaps.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
   endtask

   // Drop valid, let every expected pixel drain, then let the pipe settle.
   task automatic wait_for_idle();
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_color(input logic [CSR_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (idx == CSR_ON_COLOR) on_color_reg = value;
      else off_color_reg = value;
   endtask

   function automatic logic [COLOR_W-1:0] pick_color(input logic [COLOR_W-1:0] current);
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return current;
         default: return COLOR_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic randomize_colors();
      int which;
      wait_for_idle();
      which = $urandom_range(0, 2);
      if (which != 1) write_color(CSR_ON_COLOR, pick_color(on_color_reg));
      if (which != 0) write_color(CSR_OFF_COLOR, pick_color(off_color_reg));
   endtask

   // Never point at an unwritten entry unless the whole byte is repainted.
   function automatic int pick_position();
      if (last_position >= 0 && $urandom_range(0, 5) == 0) return last_position;
      if (repaint_forced()) return $urandom_range(0, COPY_DEPTH - 1);
      return written_positions[$urandom_range(0, written_positions.size() - 1)];
   endfunction

   function automatic logic [BITS_W-1:0] pick_bits(input int idx);
      if (!panel_written[idx]) return BITS_W'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
         0:       return panel_copy[idx];
         1:       return panel_copy[idx] ^ (8'h01 << $urandom_range(0, 7));
         2:       return 8'h00;
         3:       return 8'hFF;
         4:       return panel_copy[idx] ^ BITS_W'($urandom_range(0, 255));
         default: return BITS_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_first_frame();
      send_byte(6'd0, 2'd0, 8'h00, 1'b0);
      send_byte(6'd63, 2'd3, 8'hFF, 1'b0);
      send_byte(6'd21, 2'd2, 8'hA5, 1'b0);
      send_byte(6'd42, 2'd1, 8'h5A, 1'b1);
   endtask

   task automatic test_pixel_diff();
      send_byte(6'd0, 2'd0, 8'h01, 1'b0);
      // same position back to back: the second compare sees the first write
      send_byte(6'd0, 2'd0, 8'h81, 1'b0);
      send_byte(6'd63, 2'd3, 8'hFF, 1'b0);
      send_byte(6'd21, 2'd2, 8'h5A, 1'b0);
      send_byte(6'd42, 2'd1, 8'h5A, 1'b1);
   endtask

   task automatic test_color_change();
      wait_for_idle();
      write_color(CSR_ON_COLOR, 16'h0000);
      write_color(CSR_OFF_COLOR, 16'hFFFF);
      send_byte(6'd0, 2'd0, 8'h81, 1'b0);
      send_byte(6'd63, 2'd3, 8'h00, 1'b1);
      send_byte(6'd0, 2'd0, 8'h81, 1'b0);
      wait_for_idle();
      // rewriting the same value must not force a repaint
      write_color(CSR_ON_COLOR, 16'h0000);
      send_byte(6'd21, 2'd2, 8'h5B, 1'b1);
   endtask

   task automatic test_midframe_color();
      wait_for_idle();
      send_byte(6'd42, 2'd1, 8'h5B, 1'b0);
      wait_for_idle();
      write_color(CSR_OFF_COLOR, 16'h001F);
      send_byte(6'd21, 2'd2, 8'h5B, 1'b0);
      wait_for_idle();
      write_color(CSR_ON_COLOR, 16'hF800);
      send_byte(6'd42, 2'd1, 8'h5A, 1'b1);
      send_byte(6'd63, 2'd3, 8'h01, 1'b1);
   endtask

   // Stall the output long enough that the core fills and holds off its input.
   task automatic test_back_pressure();
      int idx;
      wait_for_idle();
      hold_off_left = 150;
      repeat (16) begin
         idx = pick_position();
         send_byte(COLUMN_W'(idx % PANEL_W), PAGE_W'(idx / PANEL_W),
                   panel_written[idx] ? ~panel_copy[idx] : 8'hC3, 1'b0);
      end
      send_byte(6'd63, 2'd3, 8'h01, 1'b1);
      wait_for_idle();
   endtask

   task automatic test_random_frames();
      int sent;
      int frame_len;
      int idx;
      bit broken;
      logic fend;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 4) == 0) randomize_colors();
         frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                 : $urandom_range(1, 16);
         broken = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < frame_len; i++) begin
            if ($urandom_range(0, 39) == 0) randomize_colors();
            idx = pick_position();
            fend = (i == frame_len - 1) ? !broken : ($urandom_range(0, 49) == 0);
            send_byte(COLUMN_W'(idx % PANEL_W), PAGE_W'(idx / PANEL_W), pick_bits(idx), fend);
            sent++;
            pace_sender();
         end
      end
   endtask

   // Output side: the stall mode is re-picked at random after each stretch; a
   // requested hold-off overrides the pattern.
   initial begin
      int mode;
      int stretch;
      int phase;
      mode = 0;
      stretch = 0;
      phase = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stretch == 0) begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(16, 96);
         end
         stretch--;
         phase++;
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
               2:       rsp_ch.ready <= (phase % 4 != 3);
               default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      pixel_write_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel write x=%0d y=%0d",
                                      rsp_ch.pixel_x, rsp_ch.pixel_y));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_ch.pixel_x !== want.x)
               report_mismatch($sformatf("pixel_x %0d, want %0d", rsp_ch.pixel_x, want.x));
            if (rsp_ch.pixel_y !== want.y)
               report_mismatch($sformatf("pixel_y %0d, want %0d", rsp_ch.pixel_y, want.y));
            if (rsp_ch.red !== want.red)
               report_mismatch($sformatf("red %h, want %h at x=%0d y=%0d",
                                         rsp_ch.red, want.red, want.x, want.y));
            if (rsp_ch.green !== want.green)
               report_mismatch($sformatf("green %h, want %h at x=%0d y=%0d",
                                         rsp_ch.green, want.green, want.x, want.y));
            if (rsp_ch.blue !== want.blue)
               report_mismatch($sformatf("blue %h, want %h at x=%0d y=%0d",
                                         rsp_ch.blue, want.blue, want.x, want.y));
            if (rsp_ch.run_last !== want.run_last)
               report_mismatch($sformatf("run_last %b, want %b at x=%0d y=%0d",
                                         rsp_ch.run_last, want.run_last, want.x, want.y));
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_ON_COLOR;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.column = '0;
      req_ch.page = '0;
      req_ch.pixel_bits = '0;
      req_ch.frame_end = 1'b0;
      error_count = 0;
      hold_off_left = 0;
      burst_left = 0;
      last_position = -1;
      first_frame_pending = 1'b1;
      latched_on_color = '0;
      latched_off_color = '0;
      on_color_reg = ON_COLOR_RST;
      off_color_reg = OFF_COLOR_RST;
      for (int i = 0; i < COPY_DEPTH; i++) begin
         panel_copy[i] = '0;
         panel_written[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_first_frame();
      test_pixel_diff();
      test_color_change();
      test_midframe_color();
      test_back_pressure();
      test_random_frames();
      wait_for_idle();

      if (error_count == 0) begin
         $display("mono_frame_diff_to_rgb888_core_tb: clean");
      end else begin
         $display("mono_frame_diff_to_rgb888_core_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mfd_pkg.sv
rtl/core/mfd_if.sv
rtl/core/mfd_frame_mem.sv
rtl/core/mfd_pixel_emit.sv
rtl/core/mono_frame_diff_to_rgb888_core.sv
tb/mono_frame_diff_to_rgb888_core_tb.sv
